>>> design/tadh_pkg.sv
// Shared types, constants and helper functions for the targeted-attack degree histogram block.
// Used by tadh_scan_unit and targeted_attack_degree_histograms; depends on nothing else.
package tadh_pkg;

    localparam int MaxNodes  = 8;
    localparam int MaskW     = 28;
    localparam int MaskIdxW  = $clog2(MaskW);
    localparam int NodeW     = 4;
    localparam int MinNodes  = 3;
    localparam int VtxW      = $clog2(MaxNodes);
    localparam int RankW     = VtxW + 1;
    localparam int DegW      = $clog2(MaxNodes);
    localparam int SumW      = $clog2(MaxNodes * (MaxNodes - 1) + 1);
    localparam int HistBins  = 8;
    localparam int CountW    = 4;
    localparam int HistW     = HistBins * CountW;
    localparam int StageW    = 3;
    localparam int EdgeW     = 5;
    localparam int OutVtxW   = 3;
    localparam int InTdataW  = 32;
    localparam int OutTdataW = 48;

    typedef logic [MaxNodes-1:0] row_t;
    typedef row_t [MaxNodes-1:0] adj_t;

    typedef struct packed {
        logic [HistW-1:0] hist;
        logic [SumW-1:0]  sum;
        logic [RankW-1:0] rank;
        logic [VtxW-1:0]  best;
        logic [VtxW-1:0]  best_orig;
        logic [DegW-1:0]  best_deg;
    } acc_t;

    typedef enum logic [2:0] {
        StIdle = 3'b001,
        StScan = 3'b010,
        StEmit = 3'b100
    } state_t;

    function automatic logic [NodeW-1:0] clamp_nodes(input logic [NodeW-1:0] v);
        logic [NodeW-1:0] r;
        r = v;
        if (v < NodeW'(MinNodes)) begin
            r = NodeW'(MinNodes);
        end else if (v > NodeW'(MaxNodes)) begin
            r = NodeW'(MaxNodes);
        end
        return r;
    endfunction

    function automatic row_t init_alive(input logic [NodeW-1:0] n);
        row_t a;
        for (int v = 0; v < MaxNodes; v++) begin
            a[v] = (v < int'(n));
        end
        return a;
    endfunction

    function automatic adj_t build_adj(input logic [MaskW-1:0] mask,
                                       input logic [NodeW-1:0] n);
        adj_t a;
        int   p;
        a = '0;
        for (int nn = MinNodes; nn <= MaxNodes; nn++) begin
            if (int'(n) == nn) begin
                p = 0;
                for (int i = 0; i < nn; i++) begin
                    for (int j = i + 1; j < nn; j++) begin
                        if (p < MaskW) begin
                            a[i][j] = mask[p[MaskIdxW-1:0]];
                            a[j][i] = mask[p[MaskIdxW-1:0]];
                        end
                        p++;
                    end
                end
            end
        end
        return a;
    endfunction

endpackage

>>> design/tadh_scan_unit.sv
// Shared scan unit: folds one vertex's degree into the running histogram, edge sum and argmax.
// Depends on tadh_pkg.
module tadh_scan_unit (
    input  tadh_pkg::row_t                row,
    input  tadh_pkg::row_t                alive,
    input  logic [tadh_pkg::VtxW-1:0]     vtx,
    input  tadh_pkg::acc_t                acc_in,
    output tadh_pkg::acc_t                acc_out
);

    logic [tadh_pkg::DegW-1:0] deg;

    always_comb begin
        deg = '0;
        for (int v = 0; v < tadh_pkg::MaxNodes; v++) begin
            deg = deg + tadh_pkg::DegW'(row[v] & alive[v]);
        end
    end

    always_comb begin
        acc_out = acc_in;
        if (alive[vtx]) begin
            acc_out.sum = acc_in.sum + tadh_pkg::SumW'(deg);
            for (int b = 0; b < tadh_pkg::HistBins; b++) begin
                if (int'(deg) == b &&
                    acc_in.hist[b*tadh_pkg::CountW +: tadh_pkg::CountW] != '1) begin
                    acc_out.hist[b*tadh_pkg::CountW +: tadh_pkg::CountW] =
                        acc_in.hist[b*tadh_pkg::CountW +: tadh_pkg::CountW] + 1'b1;
                end
            end
            if (acc_in.rank == '0 || deg > acc_in.best_deg) begin
                acc_out.best      = acc_in.rank[tadh_pkg::VtxW-1:0];
                acc_out.best_orig = vtx;
                acc_out.best_deg  = deg;
            end
            acc_out.rank = acc_in.rank + 1'b1;
        end
    end

endmodule

>>> design/targeted_attack_degree_histograms.sv
// Top level of the targeted-attack degree histogram block: sequencer, graph state, output register.
// Depends on tadh_pkg and tadh_scan_unit.
//
// Usage: one input beat on s_* carries a graph's upper-triangle edge mask. The block then
// removes its highest-degree vertex n-1 times (n is the node count register clamped to 3..8)
// and sends one m_* beat per stage; m_tlast marks the last stage of a graph.
// The cfg_* channel writes the node count; it is always ready, and the user must see that it
// is written only while idle, as the block itself does not enforce this. Timing: the shared
// scan unit handles one vertex slot per cycle; a stage scans all n slots, then loads the output
// register and removes the vertex. s_tready stays low from the accepted beat until the graph
// is done.
// The result sits in an output register; while the receiver stalls the next stage is scanned
// and then waits until the register is taken. s_tready rises again with the last result beat.
// Reset (aresetn low, synchronous) sets the node count to 8, empties the output register and
// returns to idle with s_tready high.
module targeted_attack_degree_histograms (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tadh_pkg::NodeW-1:0]         cfg_data,    // node_count
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tadh_pkg::InTdataW-1:0]      s_tdata,     // edge_mask, zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // stage, removed_vertex, max_degree, degree_histogram, residual_edges, zero fill
    output logic [tadh_pkg::OutTdataW-1:0]     m_tdata,
    output logic                               m_tlast
);

    tadh_pkg::state_t                  state_reg, state_next;
    logic [tadh_pkg::NodeW-1:0]        cfg_nodes_reg;
    logic [tadh_pkg::NodeW-1:0]        n_reg, n_next;
    tadh_pkg::adj_t                    adj_reg, adj_next;
    tadh_pkg::row_t                    alive_reg, alive_next;
    logic [tadh_pkg::VtxW-1:0]         vtx_reg, vtx_next;
    logic [tadh_pkg::StageW-1:0]       stage_reg, stage_next;
    tadh_pkg::acc_t                    acc_reg, acc_next, acc_scan;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_last_reg, out_last_next;
    logic [tadh_pkg::OutTdataW-1:0]    out_data_reg, out_data_next;
    logic                              in_fire;
    logic                              out_load;
    logic                              stage_last;
    logic [tadh_pkg::NodeW-1:0]        n_in;

    tadh_scan_unit u_scan (
        .row     (adj_reg[vtx_reg]),
        .alive   (alive_reg),
        .vtx     (vtx_reg),
        .acc_in  (acc_reg),
        .acc_out (acc_scan)
    );

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == tadh_pkg::StIdle);
    assign in_fire    = s_tvalid && s_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign n_in       = tadh_pkg::clamp_nodes(cfg_nodes_reg);
    assign stage_last = (tadh_pkg::NodeW'(stage_reg) + tadh_pkg::NodeW'(2)) == n_reg;
    assign out_load   = (state_reg == tadh_pkg::StEmit) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        adj_next       = adj_reg;
        alive_next     = alive_reg;
        vtx_next       = vtx_reg;
        stage_next     = stage_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            tadh_pkg::StIdle: begin
                if (in_fire) begin
                    n_next     = n_in;
                    adj_next   = tadh_pkg::build_adj(s_tdata[tadh_pkg::MaskW-1:0], n_in);
                    alive_next = tadh_pkg::init_alive(n_in);
                    vtx_next   = '0;
                    stage_next = '0;
                    acc_next   = '0;
                    state_next = tadh_pkg::StScan;
                end
            end
            tadh_pkg::StScan: begin
                acc_next = acc_scan;
                if (tadh_pkg::NodeW'(vtx_reg) == n_reg - 1'b1) begin
                    state_next = tadh_pkg::StEmit;
                end else begin
                    vtx_next = vtx_reg + 1'b1;
                end
            end
            tadh_pkg::StEmit: begin
                if (out_load) begin
                    out_valid_next = 1'b1;
                    out_last_next  = stage_last;
                    out_data_next  = {
                        {(tadh_pkg::OutTdataW - 3*tadh_pkg::OutVtxW - tadh_pkg::HistW
                          - tadh_pkg::EdgeW){1'b0}},
                        tadh_pkg::EdgeW'(acc_reg.sum >> 1),
                        acc_reg.hist,
                        tadh_pkg::OutVtxW'(acc_reg.best_deg),
                        tadh_pkg::OutVtxW'(acc_reg.best),
                        tadh_pkg::OutVtxW'(stage_reg)
                    };
                    alive_next[acc_reg.best_orig] = 1'b0;
                    stage_next = stage_reg + 1'b1;
                    vtx_next   = '0;
                    acc_next   = '0;
                    state_next = stage_last ? tadh_pkg::StIdle : tadh_pkg::StScan;
                end
            end
            default: begin
                state_next = tadh_pkg::StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tadh_pkg::StIdle;
            cfg_nodes_reg <= tadh_pkg::NodeW'(tadh_pkg::MaxNodes);
            out_valid_reg <= 1'b0;
            n_reg         <= tadh_pkg::NodeW'(tadh_pkg::MaxNodes);
            alive_reg     <= '0;
            vtx_reg       <= '0;
            stage_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            alive_reg     <= alive_next;
            vtx_reg       <= vtx_next;
            stage_reg     <= stage_next;
            if (cfg_valid && cfg_ready) begin
                cfg_nodes_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        adj_reg      <= adj_next;
        acc_reg      <= acc_next;
        out_last_reg <= out_last_next;
        out_data_reg <= out_data_next;
    end

    // While a graph is being processed, the number of surviving vertices matches the node count minus the stages done.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != tadh_pkg::StIdle) |->
            ($countones(alive_reg) == int'(n_reg) - int'(stage_reg)))
        else $error("alive vertex count does not match stage");

    // Loading the final stage of a graph returns the block to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && stage_last) |=> (s_tready && out_valid_reg && out_last_reg))
        else $error("block did not return to idle after the last stage");

    // The stage counter never passes the last stage of the current graph.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != tadh_pkg::StIdle) |->
            (tadh_pkg::NodeW'(stage_reg) + tadh_pkg::NodeW'(2) <= n_reg))
        else $error("stage counter overran the graph");

    // An accepted graph always starts a fresh scan at stage 0 and vertex slot 0.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == tadh_pkg::StScan && stage_reg == '0 && vtx_reg == '0))
        else $error("graph accepted without a fresh scan");

endmodule
